@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the RTL. They collapse to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When cond holds at a clock edge, prop must hold at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("assertion failed: same-cycle implication");

// When cond holds at a clock edge, prop must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

@@ rtl/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Types, character codes and the half-step table of the conveyor run control.
// ----------------------------------------------------------------------------
package scc_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [3:0] coil_t;

	// Event kinds carried on the input word.
	typedef enum logic [1:0] {
		OP_BYTE   = 2'd0,
		OP_TICK   = 2'd1,
		OP_FILTER = 2'd2,
		OP_SWITCH = 2'd3
	} op_t;

	// Keyword candidate bits.
	localparam int unsigned CAND_RUN  = 0;
	localparam int unsigned CAND_STOP = 1;
	localparam int unsigned CAND_HALT = 2;
	localparam logic [2:0]  CAND_ALL  = 3'b111;

	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_TAB   = 8'h09;
	localparam byte_t CH_LF    = 8'h0A;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_UPPER_A = 8'h41;
	localparam byte_t CH_UPPER_Z = 8'h5A;
	localparam byte_t CASE_OFFSET = 8'h20;

	// Word length saturates here.
	localparam logic [2:0] WORD_LEN_MAX = 3'd5;

	function automatic coil_t half_step(input logic [2:0] idx);
		coil_t pat;
		case (idx)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

	function automatic byte_t run_char(input logic [1:0] pos);
		byte_t ch;
		case (pos)
			2'd0: ch = "r";
			2'd1: ch = "u";
			2'd2: ch = "n";
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

	function automatic byte_t stop_char(input logic [1:0] pos);
		byte_t ch;
		case (pos)
			2'd0: ch = "s";
			2'd1: ch = "t";
			2'd2: ch = "o";
			2'd3: ch = "p";
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

	function automatic byte_t halt_char(input logic [1:0] pos);
		byte_t ch;
		case (pos)
			2'd0: ch = "h";
			2'd1: ch = "a";
			2'd2: ch = "l";
			2'd3: ch = "t";
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/stepper_conveyor_run_control.sv @@
// ----------------------------------------------------------------------------
// stepper_conveyor_run_control
// Conveyor run latch, half-step coil sequencer and command-line word scanner.
// ----------------------------------------------------------------------------
// Each input word is one event: a received command byte, a step tick, a
// filter-sensor interrupt or a completed run-switch press, all carrying the
// qualified filter-present level. Every event produces exactly one result word
// holding the coil drive and the run latch as they stand after that event. The
// block takes one word per clock while in_stall is low. The event is first
// captured in an input register, then one short pass of logic updates the
// control state and loads the result register for output. Input stall
// only rises when the result register is full and the far side is stalling,
// so with the output drained the sustained rate is one event per cycle. The
// run latch comes out of reset set, the coils low. The run-switch enable
// register resets to one and is written through its own valid/ready port,
// which is always ready; it should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module stepper_conveyor_run_control #(
	parameter int LINE_CAPACITY = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	// Configuration write channel.
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data,
	// Event input channel.
	input  logic           in_valid,
	output logic           in_stall,
	input  scc_pkg::op_t   operation,
	input  logic [7:0]     byte_value,
	input  logic           filter_level,
	// Result output channel.
	output logic           out_valid,
	input  logic           out_stall,
	output scc_pkg::coil_t coil_pattern,
	output logic           run_latched
);

	import scc_pkg::*;

	`include "assert_macros.svh"

	// The line counter only ever holds up to LINE_CAPACITY - 1.
	localparam int LenW = $clog2(LINE_CAPACITY);
	localparam logic [LenW-1:0] LenLimit = LenW'(LINE_CAPACITY - 1);

	// ------------------------------------------------------------------
	// Handshake
	// ------------------------------------------------------------------
	logic in_fire;
	logic adv_s1;
	logic valid_s1;
	logic out_valid_q;

	// Stage one moves on whenever the result register is empty or is being
	// emptied this cycle.
	assign adv_s1   = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~adv_s1;
	assign in_fire  = in_valid & ~in_stall;

	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic sw_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			sw_enable_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	op_t   op_s1;
	byte_t byte_s1;
	logic  filter_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= operation;
			byte_s1   <= byte_value;
			filter_s1 <= filter_level;
		end
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	logic            run_q;
	logic [2:0]      phase_q;
	coil_t           coil_q;
	logic [LenW-1:0] line_len_q;
	logic            lead_q;
	logic [2:0]      word_len_q;
	logic [2:0]      cand_q;
	logic            nul_seen_q;

	logic            run_d;
	logic [2:0]      phase_d;
	coil_t           coil_d;
	logic [LenW-1:0] line_len_d;
	logic            lead_d;
	logic [2:0]      word_len_d;
	logic [2:0]      cand_d;
	logic            nul_seen_d;

	byte_t      ch_lc;
	logic [1:0] pos2;
	logic       run_req;
	logic       stop_req;

	// Lower-cased byte and the low bits of the word position, which index the
	// keyword letters while the position is in range.
	always_comb begin
		ch_lc = byte_s1;
		if ((byte_s1 >= CH_UPPER_A) && (byte_s1 <= CH_UPPER_Z)) begin
			ch_lc = byte_s1 + CASE_OFFSET;
		end
	end

	assign pos2 = word_len_q[1:0];

	// A line end decides on the word gathered so far: a one-letter word counts
	// only as r or s, so the candidate bits tell them apart.
	always_comb begin
		run_req  = ((word_len_q == 3'd3) && cand_q[CAND_RUN]) ||
			((word_len_q == 3'd1) && cand_q[CAND_RUN]);
		stop_req = ((word_len_q == 3'd4) && (cand_q[CAND_STOP] || cand_q[CAND_HALT])) ||
			((word_len_q == 3'd1) && cand_q[CAND_STOP]);
	end

	always_comb begin
		run_d      = run_q;
		phase_d    = phase_q;
		coil_d     = coil_q;
		line_len_d = line_len_q;
		lead_d     = lead_q;
		word_len_d = word_len_q;
		cand_d     = cand_q;
		nul_seen_d = nul_seen_q;

		case (op_s1)
			OP_BYTE: begin
				if ((byte_s1 == CH_CR) || (byte_s1 == CH_LF)) begin
					if (run_req && !filter_s1) begin
						run_d = 1'b1;
					end
					if (stop_req) begin
						run_d  = 1'b0;
						coil_d = '0;
					end
					line_len_d = '0;
					lead_d     = 1'b1;
					word_len_d = '0;
					cand_d     = CAND_ALL;
					nul_seen_d = 1'b0;
				end else if (line_len_q < LenLimit) begin
					line_len_d = line_len_q + 1'b1;
					if (!nul_seen_q) begin
						if (byte_s1 == CH_NUL) begin
							nul_seen_d = 1'b1;
						end else if (!(lead_q && ((ch_lc == CH_SPACE) || (ch_lc == CH_TAB)))) begin
							lead_d = 1'b0;
							if ((word_len_q >= 3'd3) || (ch_lc != run_char(pos2))) begin
								cand_d[CAND_RUN] = 1'b0;
							end
							if ((word_len_q >= 3'd4) || (ch_lc != stop_char(pos2))) begin
								cand_d[CAND_STOP] = 1'b0;
							end
							if ((word_len_q >= 3'd4) || (ch_lc != halt_char(pos2))) begin
								cand_d[CAND_HALT] = 1'b0;
							end
							if (word_len_q < WORD_LEN_MAX) begin
								word_len_d = word_len_q + 3'd1;
							end
						end
					end
				end
			end
			OP_TICK: begin
				if (!run_q) begin
					coil_d = '0;
				end else if (filter_s1) begin
					run_d  = 1'b0;
					coil_d = '0;
				end else begin
					coil_d  = half_step(phase_q);
					phase_d = phase_q + 3'd1;
				end
			end
			OP_FILTER: begin
				if (filter_s1) begin
					run_d  = 1'b0;
					coil_d = '0;
				end
			end
			OP_SWITCH: begin
				if (sw_enable_q && !filter_s1) begin
					run_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b1;
			phase_q    <= '0;
			coil_q     <= '0;
			line_len_q <= '0;
			lead_q     <= 1'b1;
			word_len_q <= '0;
			cand_q     <= CAND_ALL;
			nul_seen_q <= 1'b0;
		end else if (adv_s1) begin
			run_q      <= run_d;
			phase_q    <= phase_d;
			coil_q     <= coil_d;
			line_len_q <= line_len_d;
			lead_q     <= lead_d;
			word_len_q <= word_len_d;
			cand_q     <= cand_d;
			nul_seen_q <= nul_seen_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	coil_t coil_out_q;
	logic  run_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			coil_out_q <= coil_d;
			run_out_q  <= run_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign coil_pattern = coil_out_q;
	assign run_latched  = run_out_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`ASSERT_IMPLY(a_coils_need_run, clk, arst_n, coil_q != 4'h0, run_q)
	`ASSERT_IMPLY(a_line_len_bound, clk, arst_n, 1'b1, line_len_q <= LenLimit)
	`ASSERT_IMPLY(a_word_len_bound, clk, arst_n, 1'b1, word_len_q <= WORD_LEN_MAX)
	`ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, in_stall,
		valid_s1 && out_valid_q && out_stall)
	`ASSERT_NEXT(a_advance_fills_output, clk, arst_n, adv_s1, out_valid_q)

endmodule

@@ verif/scc_run_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scc_run_checker
// Watches the event, result and configuration channels of the conveyor run
// control, predicts the coil drive and run latch for every event word and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module scc_run_checker #(
	parameter int LINE_CAPACITY = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic           cfg_data,
	input  logic           in_valid,
	input  logic           in_stall,
	input  scc_pkg::op_t   operation,
	input  scc_pkg::byte_t byte_value,
	input  logic           filter_level,
	input  logic           out_valid,
	input  logic           out_stall,
	input  scc_pkg::coil_t coil_pattern,
	input  logic           run_latched,
	output int             outstanding,
	output int             mismatches,
	output int             words_checked
);

	import scc_pkg::*;

	typedef struct packed {
		coil_t coils;
		logic  latch;
	} drive_word_t;

	// Half-step sequence, entry 0 in the low nibble.
	localparam logic [31:0] HALF_STEP_SEQ = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};
	localparam logic [23:0] RUN_WORD  = "run";
	localparam logic [31:0] STOP_WORD = "stop";
	localparam logic [31:0] HALT_WORD = "halt";

	drive_word_t expected_drive[$];

	logic        switch_enable;
	logic        latch_q;
	logic [2:0]  phase_q;
	coil_t       coils_q;
	int unsigned line_len;
	logic        blanks_q;
	logic [2:0]  word_len;
	logic [2:0]  cands_q;
	logic        nul_q;

	task automatic log_mismatch(input string msg);
		if (mismatches < 30)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void clear_line_state();
		line_len = 0;
		blanks_q = 1'b1;
		word_len = '0;
		cands_q  = CAND_ALL;
		nul_q    = 1'b0;
	endfunction

	function automatic void scan_byte(input byte_t c);
		byte_t       ch;
		int unsigned pos;
		ch = c;
		if (nul_q)
			return;
		if (ch == CH_NUL) begin
			nul_q = 1'b1;
			return;
		end
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
			ch = ch + CASE_OFFSET;
		if (blanks_q && (ch == CH_SPACE || ch == CH_TAB))
			return;
		blanks_q = 1'b0;
		pos = word_len;
		if (pos < 3) begin
			if (ch != RUN_WORD[(2 - pos) * 8 +: 8])
				cands_q[CAND_RUN] = 1'b0;
		end else begin
			cands_q[CAND_RUN] = 1'b0;
		end
		if (pos < 4) begin
			if (ch != STOP_WORD[(3 - pos) * 8 +: 8])
				cands_q[CAND_STOP] = 1'b0;
			if (ch != HALT_WORD[(3 - pos) * 8 +: 8])
				cands_q[CAND_HALT] = 1'b0;
		end else begin
			cands_q[CAND_STOP] = 1'b0;
			cands_q[CAND_HALT] = 1'b0;
		end
		if (word_len < WORD_LEN_MAX)
			word_len++;
	endfunction

	function automatic void finish_line(input logic filt);
		logic run_req;
		logic stop_req;
		run_req  = (word_len == 3'd3 || word_len == 3'd1) && cands_q[CAND_RUN];
		stop_req = (word_len == 3'd4 && (cands_q[CAND_STOP] || cands_q[CAND_HALT]))
			|| (word_len == 3'd1 && cands_q[CAND_STOP]);
		if (run_req && !filt)
			latch_q = 1'b1;
		if (stop_req) begin
			latch_q = 1'b0;
			coils_q = '0;
		end
		clear_line_state();
	endfunction

	function automatic drive_word_t step_conveyor(input op_t op, input byte_t b, input logic filt);
		drive_word_t w;
		case (op)
			OP_BYTE: begin
				if (b == CH_CR || b == CH_LF) begin
					finish_line(filt);
				end else if (line_len < LINE_CAPACITY - 1) begin
					line_len++;
					scan_byte(b);
				end
			end
			OP_TICK: begin
				if (!latch_q) begin
					coils_q = '0;
				end else if (filt) begin
					latch_q = 1'b0;
					coils_q = '0;
				end else begin
					coils_q = HALF_STEP_SEQ[phase_q * 4 +: 4];
					phase_q = phase_q + 3'd1;
				end
			end
			OP_FILTER: begin
				if (filt) begin
					latch_q = 1'b0;
					coils_q = '0;
				end
			end
			default: begin
				if (switch_enable && !filt)
					latch_q = 1'b1;
			end
		endcase
		w.coils = coils_q;
		w.latch = latch_q;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		drive_word_t want;
		if (!arst_n) begin
			switch_enable = 1'b1;
			latch_q = 1'b1;
			phase_q = '0;
			coils_q = '0;
			clear_line_state();
			expected_drive.delete();
			mismatches = 0;
			words_checked = 0;
			outstanding <= 0;
		end else begin
			// The result leaving at this edge belongs to an earlier event, so it is
			// matched before this edge's event is predicted.
			if (out_valid && !out_stall) begin
				if (expected_drive.size() == 0) begin
					log_mismatch("result word with no event outstanding");
				end else begin
					want = expected_drive.pop_front();
					if (coil_pattern !== want.coils)
						log_mismatch($sformatf("coil_pattern %h, expected %h",
							coil_pattern, want.coils));
					if (run_latched !== want.latch)
						log_mismatch($sformatf("run_latched %b, expected %b",
							run_latched, want.latch));
					words_checked++;
				end
			end
			if (cfg_valid && cfg_ready)
				switch_enable = cfg_data;
			if (in_valid && !in_stall)
				expected_drive.push_back(step_conveyor(operation, byte_value, filter_level));
			outstanding <= expected_drive.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the conveyor run control. Drives a directed run
// over the special cases, then random traffic made mostly of well-formed
// command lines mixed with step ticks, filter and switch events, under three
// different stall patterns and both run-switch enable settings. All
// checking happens in scc_run_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module tb_top;
	import scc_pkg::*;

	localparam int LINE_CAPACITY = 24;
	// Far above the slowest correct run.
	localparam int CYCLE_LIMIT   = 400000;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_valid;
	logic  cfg_ready;
	logic  cfg_data;
	logic  in_valid;
	logic  in_stall;
	op_t   operation;
	byte_t byte_value;
	logic  filter_level;
	logic  out_valid;
	logic  out_stall = 1'b0;
	coil_t coil_pattern;
	logic  run_latched;

	int outstanding;
	int mismatches;
	int words_checked;

	// Percentages of cycles in which the sender holds back and the receiver
	// stalls; the stimulus changes them from one phase to the next.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int events_sent   = 0;
	int lines_sent    = 0;
	int cycle_count   = 0;
	int op_count [4];

	stepper_conveyor_run_control #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.byte_value     (byte_value),
		.filter_level   (filter_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.coil_pattern   (coil_pattern),
		.run_latched    (run_latched)
	);

	scc_run_checker #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.byte_value     (byte_value),
		.filter_level   (filter_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.coil_pattern   (coil_pattern),
		.run_latched    (run_latched),
		.outstanding    (outstanding),
		.mismatches     (mismatches),
		.words_checked  (words_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls at random, at whatever rate the current phase sets.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Watchdog: a hung block or a lost result word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d result words outstanding",
				cycle_count, outstanding);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one event word and returns at the edge that accepts it. Random
	// idle cycles come first, so the gaps land in front of every kind of event.
	// The payload is left untouched while the block stalls.
	task automatic send_event(input op_t op, input byte_t b, input logic filt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		byte_value   <= b;
		filter_level <= filt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		events_sent++;
		op_count[op]++;
	endtask

	// Holds the sender back until every predicted result word has come out,
	// then lets the pipeline settle for a few more cycles.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// The enable register is only touched with the block idle.
	task automatic write_switch_enable(input logic value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One command line: optional leading blanks (now and then enough to run
	// past the line buffer), a keyword or a near miss in random case, an
	// optional zero byte with trailing rubbish, then CR or LF.
	task automatic send_command_line();
		string word;
		byte_t ch;
		int    pad;
		int    tail;
		case ($urandom_range(0, 15))
			0, 1, 2: word = "run";
			3, 4:    word = "r";
			5, 6, 7: word = "stop";
			8, 9:    word = "halt";
			10:      word = "s";
			11:      word = "runs";
			12:      word = "ru";
			13:      word = "sto";
			14:      word = "h";
			default: word = "";
		endcase
		pad = ($urandom_range(0, 11) == 0) ? $urandom_range(18, 26) : $urandom_range(0, 3);
		for (int i = 0; i < pad; i++)
			send_event(OP_BYTE, $urandom_range(0, 1) ? CH_SPACE : CH_TAB,
				1'($urandom_range(0, 1)));
		for (int i = 0; i < word.len(); i++) begin
			ch = word[i];
			if ($urandom_range(0, 1))
				ch = ch - CASE_OFFSET;
			send_event(OP_BYTE, ch, 1'($urandom_range(0, 1)));
		end
		tail = $urandom_range(0, 9);
		if (tail < 2) begin
			send_event(OP_BYTE, CH_NUL, 1'($urandom_range(0, 1)));
			repeat ($urandom_range(0, 2))
				send_event(OP_BYTE, byte_t'($urandom_range(1, 255)),
					1'($urandom_range(0, 1)));
		end else if (tail == 2) begin
			send_event(OP_BYTE, "x", 1'($urandom_range(0, 1)));
		end
		send_event(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, $urandom_range(0, 6) == 0);
		lines_sent++;
	endtask

	// Random traffic at one stall setting. Ticks dominate so that the sequencer
	// walks its whole table; command lines keep re-arming and stopping the
	// latch; a small share is raw noise over every field.
	task automatic run_phase(input int send_pct, input int recv_pct, input int item_count);
		int stop_at;
		int pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = events_sent + item_count;
		while (events_sent < stop_at) begin
			pick = $urandom_range(0, 199);
			if (pick < 80)
				send_event(OP_TICK, byte_t'($urandom), $urandom_range(0, 9) == 0);
			else if (pick < 96)
				send_event(OP_FILTER, byte_t'($urandom), 1'($urandom_range(0, 1)));
			else if (pick < 112)
				send_event(OP_SWITCH, byte_t'($urandom), $urandom_range(0, 3) == 0);
			else if (pick < 184)
				send_command_line();
			else if (pick < 199)
				send_event(op_t'($urandom_range(0, 3)), byte_t'($urandom),
					1'($urandom_range(0, 1)));
			else
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = 1'b0;
		in_valid       = 1'b0;
		operation      = OP_BYTE;
		byte_value     = '0;
		filter_level   = 1'b0;
		for (int i = 0; i < 4; i++)
			op_count[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the enable register at its reset value of one.
		// Two steps from reset, then an upper-case single-letter stop.
		send_event(OP_TICK, 8'h00, 1'b0);
		send_event(OP_TICK, 8'hFF, 1'b0);
		send_event(OP_BYTE, "S", 1'b0);
		send_event(OP_BYTE, CH_CR, 1'b0);
		// A tick with the latch clear only keeps the coils low.
		send_event(OP_TICK, 8'h00, 1'b0);
		// Blanks ahead of the word are skipped; the run request is refused
		// because a filter is present on the line end.
		send_event(OP_BYTE, CH_SPACE, 1'b0);
		send_event(OP_BYTE, CH_TAB, 1'b0);
		send_event(OP_BYTE, "r", 1'b0);
		send_event(OP_BYTE, CH_LF, 1'b1);
		// The same request with no filter sets the latch, coils untouched.
		send_event(OP_BYTE, "r", 1'b0);
		send_event(OP_BYTE, CH_LF, 1'b0);
		// A filter seen on a tick stops the conveyor.
		send_event(OP_TICK, 8'h00, 1'b1);
		// Switch press re-arms; a filter interrupt with no filter does nothing,
		// one with a filter stops again.
		send_event(OP_SWITCH, 8'h00, 1'b0);
		send_event(OP_FILTER, 8'h00, 1'b0);
		send_event(OP_FILTER, 8'hFF, 1'b1);
		// A zero byte ends the word "run"; what follows it is ignored.
		send_event(OP_BYTE, "R", 1'b0);
		send_event(OP_BYTE, "u", 1'b0);
		send_event(OP_BYTE, "N", 1'b0);
		send_event(OP_BYTE, CH_NUL, 1'b0);
		send_event(OP_BYTE, "x", 1'b1);
		send_event(OP_BYTE, CH_CR, 1'b0);
		// Top byte value on a line of its own, a switch press blocked by the
		// filter, and one more step.
		send_event(OP_BYTE, 8'hFF, 1'b1);
		send_event(OP_BYTE, CH_LF, 1'b0);
		send_event(OP_SWITCH, 8'hFF, 1'b1);
		send_event(OP_TICK, 8'h00, 1'b0);
		drain_results();

		// Random part in three stall patterns, the last one at both enable settings.
		write_switch_enable(1'b0);
		run_phase(9, 67, 530);
		write_switch_enable(1'b1);
		run_phase(67, 9, 530);
		write_switch_enable(1'b0);
		run_phase(0, 0, 270);
		write_switch_enable(1'b1);
		run_phase(0, 0, 270);

		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d events (%0d bytes in %0d command lines, %0d ticks, %0d filter, %0d switch)",
			events_sent, op_count[OP_BYTE], lines_sent, op_count[OP_TICK],
			op_count[OP_FILTER], op_count[OP_SWITCH]);
		$display("Checked %0d result words across three stall patterns and both enable settings",
			words_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/scc_pkg.sv
rtl/stepper_conveyor_run_control.sv
verif/scc_run_checker.sv
verif/tb_top.sv
